[hdl/lpc_pkg.sv]
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types, character codes and the column formatting step of the line
// printer canonicalizer.
// ----------------------------------------------------------------------------
package lpc_pkg;

  localparam int unsigned COLUMN_LIMIT = 1000;
  localparam int unsigned TAB_STOP     = 8;
  localparam int unsigned MAX_RES      = 6;
  localparam int unsigned COL_W        = 10;
  localparam int unsigned CNT_W        = 3;

  // operating modes; code 3 runs as canonical
  localparam logic [1:0] MODE_RAW   = 2'd0;
  localparam logic [1:0] MODE_CANON = 2'd1;
  localparam logic [1:0] MODE_CAP   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_MAX_COL = 2'd1;

  localparam logic [1:0]       MODE_RST    = MODE_CANON;
  localparam logic [COL_W-1:0] MAX_COL_RST = 10'd132;

  // character codes
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_GRAVE  = 8'h60;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_VBAR   = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  typedef struct packed {
    logic [COL_W-1:0] lc;
    logic [COL_W-1:0] pc;
    logic             top;
  } col_state_t;

  typedef struct packed {
    logic [7:0]       data;
    logic [COL_W-1:0] rep;
  } res_t;

  typedef struct packed {
    col_state_t       st;
    logic             cr;
    logic             sp;
    logic [COL_W-1:0] sp_cnt;
    logic             ch;
    logic [7:0]       chr;
  } canon_res_t;

  typedef struct packed {
    res_t [2:0] ent;
    logic [1:0] cnt;
  } res3_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] ent;
    logic [CNT_W-1:0]   cnt;
  } res_list_t;

  // One canonical step: column motion plus up to CR, space run, character.
  function automatic canon_res_t canon_step(col_state_t st, logic [7:0] c,
                                            logic [COL_W-1:0] max_col);
    canon_res_t       r;
    logic [COL_W:0]   lc;
    logic [COL_W-1:0] pc;
    r     = '0;
    lc    = {1'b0, st.lc};
    pc    = st.pc;
    r.st.top = st.top;
    case (c)
      CH_SP: begin
        lc = lc + 11'd1;
      end
      CH_TAB: begin
        lc = lc - (lc % 11'(TAB_STOP)) + 11'(TAB_STOP);
      end
      CH_FF: begin
        if (!(st.top && pc == '0)) begin
          r.ch     = 1'b1;
          r.chr    = c;
          r.st.top = 1'b1;
          pc       = '0;
          lc       = '0;
        end
      end
      CH_LF: begin
        r.ch     = 1'b1;
        r.chr    = c;
        r.st.top = 1'b0;
        lc       = '0;
      end
      CH_CR: begin
        lc = '0;
      end
      CH_BS: begin
        if (lc != '0) lc = lc - 11'd1;
      end
      default: begin
        // head past target: return carriage first
        if (lc < {1'b0, pc}) begin
          r.cr = 1'b1;
          pc   = '0;
        end
        if (lc < {1'b0, max_col}) begin
          if (lc > {1'b0, pc}) begin
            r.sp     = 1'b1;
            r.sp_cnt = lc[COL_W-1:0] - pc;
            pc       = lc[COL_W-1:0];
          end
          r.ch  = 1'b1;
          r.chr = c;
          pc    = pc + 10'd1;
        end
        lc = lc + 11'd1;
      end
    endcase
    if (lc > 11'(COLUMN_LIMIT)) lc = 11'(COLUMN_LIMIT);
    r.st.lc = lc[COL_W-1:0];
    r.st.pc = pc;
    return r;
  endfunction

  // Compact the emitted pieces of one step in order.
  function automatic res3_t pack_canon(canon_res_t r);
    res3_t p;
    p = '0;
    if (r.cr) begin
      p.ent[p.cnt] = '{data: CH_CR, rep: 10'd1};
      p.cnt = p.cnt + 2'd1;
    end
    if (r.sp) begin
      p.ent[p.cnt] = '{data: CH_SP, rep: r.sp_cnt};
      p.cnt = p.cnt + 2'd1;
    end
    if (r.ch) begin
      p.ent[p.cnt] = '{data: r.chr, rep: 10'd1};
      p.cnt = p.cnt + 2'd1;
    end
    return p;
  endfunction

  // Overstrike substitute in cap mode, zero when the character has none.
  function automatic logic [7:0] cap_sub(logic [7:0] c);
    logic [7:0] s;
    case (c)
      CH_LBRACE: s = CH_LPAREN;
      CH_RBRACE: s = CH_RPAREN;
      CH_GRAVE:  s = CH_QUOTE;
      CH_VBAR:   s = CH_BANG;
      CH_TILDE:  s = CH_CARET;
      default:   s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c >= CH_LOW_A && c <= CH_LOW_Z) u = c - CASE_DIFF;
    return u;
  endfunction

endpackage

[hdl/lpc_cfg.sv]
// ----------------------------------------------------------------------------
// lpc_cfg
// Configuration registers: operating mode and printable column count.
// ----------------------------------------------------------------------------
module lpc_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [lpc_pkg::COL_W-1:0]  cfg_data,
  output logic [1:0]                 mode,
  output logic [lpc_pkg::COL_W-1:0]  max_col
);

  logic [1:0]                mode_r;
  logic [lpc_pkg::COL_W-1:0] max_col_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= lpc_pkg::MODE_RST;
      max_col_r <= lpc_pkg::MAX_COL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        lpc_pkg::REG_MODE:    mode_r    <= cfg_data[1:0];
        lpc_pkg::REG_MAX_COL: max_col_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign mode    = mode_r;
  assign max_col = max_col_r;

endmodule

[hdl/lpc_fmt.sv]
// ----------------------------------------------------------------------------
// lpc_fmt
// Column state and the single-pass formatter that turns one character into
// an ordered list of up to six printer results.
// ----------------------------------------------------------------------------
module lpc_fmt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_fire,
  input  logic [7:0]                char_in,
  input  logic [1:0]                mode,
  input  logic [lpc_pkg::COL_W-1:0] max_col,
  output lpc_pkg::res_list_t        res_list
);

  lpc_pkg::col_state_t st_r, st_nxt;
  lpc_pkg::canon_res_t r_dash, r_bs, r_main;
  lpc_pkg::col_state_t main_in;
  lpc_pkg::res3_t      p_dash, p_main;
  logic [7:0]          sub;
  logic                has_sub;
  logic [7:0]          chr_eff;
  logic [2:0]          j;

  always_comb begin
    sub     = lpc_pkg::cap_sub(char_in);
    has_sub = (mode == lpc_pkg::MODE_CAP) && (sub != 8'h00);
    if (mode == lpc_pkg::MODE_CAP) begin
      chr_eff = has_sub ? sub : lpc_pkg::to_upper(char_in);
    end else begin
      chr_eff = char_in;
    end
    // overstrike: dash, back up one column, then the substitute
    r_dash  = lpc_pkg::canon_step(st_r, lpc_pkg::CH_DASH, max_col);
    r_bs    = lpc_pkg::canon_step(r_dash.st, lpc_pkg::CH_BS, max_col);
    main_in = has_sub ? r_bs.st : st_r;
    r_main  = lpc_pkg::canon_step(main_in, chr_eff, max_col);
    p_dash  = has_sub ? lpc_pkg::pack_canon(r_dash) : '0;
    p_main  = lpc_pkg::pack_canon(r_main);
  end

  always_comb begin
    res_list = '0;
    j        = '0;
    if (mode == lpc_pkg::MODE_RAW) begin
      res_list.ent[0] = '{data: char_in, rep: 10'd1};
      res_list.cnt    = 3'd1;
      st_nxt          = st_r;
    end else begin
      for (int i = 0; i < lpc_pkg::MAX_RES; i++) begin
        j = 3'(i) - {1'b0, p_dash.cnt};
        if (3'(i) < {1'b0, p_dash.cnt}) begin
          res_list.ent[i] = p_dash.ent[i % 3];
        end else if (j < {1'b0, p_main.cnt}) begin
          res_list.ent[i] = p_main.ent[j[1:0]];
        end
      end
      res_list.cnt = {1'b0, p_dash.cnt} + {1'b0, p_main.cnt};
      st_nxt       = r_main.st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{lc: '0, pc: '0, top: 1'b1};
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

endmodule

[hdl/lpc_seq.sv]
// ----------------------------------------------------------------------------
// lpc_seq
// Result queue: loads a formatted list and drains it one beat per ready cycle.
// ----------------------------------------------------------------------------
module lpc_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  lpc_pkg::res_list_t        res_list,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lpc_pkg::res_t             out_res,
  output logic                      out_last
);

  lpc_pkg::res_t [lpc_pkg::MAX_RES-1:0] q_r, q_nxt;
  logic [lpc_pkg::CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                                 pop;
  logic                                 load;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  // take a new item once the last queued beat leaves
  assign in_ready  = (cnt_r == '0) || (cnt_r == 3'd1 && out_ready);
  assign load      = in_valid && in_ready;

  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (load) begin
      q_nxt   = res_list.ent;
      cnt_nxt = res_list.cnt;
    end else if (pop) begin
      for (int i = 0; i < lpc_pkg::MAX_RES - 1; i++) q_nxt[i] = q_r[i+1];
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_res  = q_r[0];
  assign out_last = (cnt_r == 3'd1);

endmodule

[hdl/line_printer_canonicalizer.sv]
// ----------------------------------------------------------------------------
// line_printer_canonicalizer
// The first result of an item is valid in the cycle after acceptance. One item
// per cycle while each gives at most one result and out_ready is high; an item
// with more results holds the next until its last result has left the queue,
// which sends one beat per cycle while out_ready is high. Reset (synchronous):
// columns zero, top of page set, canonical mode, 132 columns, queue empty.
// ----------------------------------------------------------------------------
module line_printer_canonicalizer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_char_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_byte,
  output logic [lpc_pkg::COL_W-1:0] out_repeat_count,
  output logic                      out_last_of_run,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [lpc_pkg::COL_W-1:0] cfg_data
);

  logic [1:0]                mode;
  logic [lpc_pkg::COL_W-1:0] max_col;
  lpc_pkg::res_list_t        res_list;
  lpc_pkg::res_t             out_res;
  logic                      in_fire;

  assign in_fire = in_valid && in_ready;

  lpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mode      (mode),
    .max_col   (max_col)
  );

  lpc_fmt u_fmt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .char_in  (in_char_in),
    .mode     (mode),
    .max_col  (max_col),
    .res_list (res_list)
  );

  lpc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .res_list  (res_list),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .out_last  (out_last_of_run)
  );

  assign out_byte         = out_res.data;
  assign out_repeat_count = out_res.rep;

endmodule

[tb/line_printer_canonicalizer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_printer_canonicalizer_test
// Drives character beats through the line printer canonicalizer in raw,
// canonical, cap and spare mode under several column widths. A column model
// in the bench predicts every printer beat, and each beat is checked in order.
// ----------------------------------------------------------------------------
module line_printer_canonicalizer_test;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         DRAIN_LIMIT = 20000;
  localparam int         RANDOM_PHASES = 10;
  localparam int         PHASE_CHARS = 12;

  typedef struct {
    logic [7:0]                data;
    logic [lpc_pkg::COL_W-1:0] rep;
    logic                      last;
  } printer_beat_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                in_char_in = 8'h00;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [7:0]                out_byte;
  logic [lpc_pkg::COL_W-1:0] out_repeat_count;
  logic                      out_last_of_run;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [1:0]                cfg_index = lpc_pkg::REG_MODE;
  logic [lpc_pkg::COL_W-1:0] cfg_data = '0;

  // column model of the printer
  logic [1:0]                cur_mode = lpc_pkg::MODE_RST;
  logic [lpc_pkg::COL_W-1:0] cur_max_col = lpc_pkg::MAX_COL_RST;
  int                        print_col = 0;
  int                        head_col = 0;
  bit                        at_page_top = 1'b1;

  printer_beat_t    step_beats[$];
  printer_beat_t    printer_beats_due[$];
  printer_beat_t    due_beat;

  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int stall_left = 0;
  int stall_len;
  int cycle_count = 0;
  int fail_count = 0;
  int chars_sent = 0;
  int beats_checked = 0;
  int cfg_settings = 0;

  line_printer_canonicalizer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_in       (in_char_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_repeat_count (out_repeat_count),
    .out_last_of_run  (out_last_of_run),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap(input bit en);
    int r;
    if (!en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // ---------------------------------------------------------------------------
  // column model
  // ---------------------------------------------------------------------------
  function automatic void add_beat(input logic [7:0] b, input int rep);
    printer_beat_t pb;
    if (step_beats.size() >= lpc_pkg::MAX_RES) return;
    pb.data = b;
    pb.rep  = rep[lpc_pkg::COL_W-1:0];
    pb.last = 1'b0;
    step_beats.push_back(pb);
  endfunction

  function automatic void place_char(input logic [7:0] ch);
    int lc;
    int pc;
    lc = print_col;
    pc = head_col;
    case (ch)
      lpc_pkg::CH_SP:  lc++;
      lpc_pkg::CH_TAB: lc = (lc / lpc_pkg::TAB_STOP + 1) * lpc_pkg::TAB_STOP;
      lpc_pkg::CH_FF: begin
        if (!(at_page_top && pc == 0)) begin
          add_beat(ch, 1);
          at_page_top = 1'b1;
          pc = 0;
          lc = 0;
        end
      end
      lpc_pkg::CH_LF: begin
        add_beat(ch, 1);
        at_page_top = 1'b0;
        lc = 0;
      end
      lpc_pkg::CH_CR: lc = 0;
      lpc_pkg::CH_BS: if (lc > 0) lc--;
      default: begin
        // head past the target column: return carriage first
        if (lc < pc) begin
          add_beat(lpc_pkg::CH_CR, 1);
          pc = 0;
        end
        if (lc < cur_max_col) begin
          if (lc > pc) begin
            add_beat(lpc_pkg::CH_SP, lc - pc);
            pc = lc;
          end
          add_beat(ch, 1);
          pc++;
        end
        lc++;
      end
    endcase
    if (lc > lpc_pkg::COLUMN_LIMIT) lc = lpc_pkg::COLUMN_LIMIT;
    print_col = lc;
    head_col  = pc;
  endfunction

  function automatic void format_char(input logic [7:0] ch);
    logic [7:0] c;
    logic [7:0] sub;
    c = ch;
    step_beats.delete();
    if (cur_mode == lpc_pkg::MODE_RAW) begin
      add_beat(c, 1);
    end else if (cur_mode == lpc_pkg::MODE_CAP) begin
      case (c)
        lpc_pkg::CH_LBRACE: sub = lpc_pkg::CH_LPAREN;
        lpc_pkg::CH_RBRACE: sub = lpc_pkg::CH_RPAREN;
        lpc_pkg::CH_GRAVE:  sub = lpc_pkg::CH_QUOTE;
        lpc_pkg::CH_VBAR:   sub = lpc_pkg::CH_BANG;
        lpc_pkg::CH_TILDE:  sub = lpc_pkg::CH_CARET;
        default:            sub = 8'h00;
      endcase
      if (sub != 8'h00) begin
        place_char(lpc_pkg::CH_DASH);
        place_char(lpc_pkg::CH_BS);
        c = sub;
      end else if (c >= lpc_pkg::CH_LOW_A && c <= lpc_pkg::CH_LOW_Z) begin
        c = c - lpc_pkg::CASE_DIFF;
      end
      place_char(c);
    end else begin
      place_char(c);
    end
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
    foreach (step_beats[k]) printer_beats_due.push_back(step_beats[k]);
  endfunction

  // ---------------------------------------------------------------------------
  // channel tasks
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] ch);
    int gap;
    gap = pick_gap(gaps_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    format_char(ch);
    chars_sent++;
  endtask

  // drop valid and hold until every predicted beat has been checked
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (printer_beats_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx,
                           input logic [lpc_pkg::COL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == lpc_pkg::REG_MODE) cur_mode = val[1:0];
    else cur_max_col = val;
  endtask

  task automatic set_config(input logic [1:0] m,
                            input logic [lpc_pkg::COL_W-1:0] cols);
    wait_idle();
    write_reg(lpc_pkg::REG_MODE, {{(lpc_pkg::COL_W-2){1'b0}}, m});
    write_reg(lpc_pkg::REG_MAX_COL, cols);
    cfg_valid <= 1'b0;
    cfg_settings++;
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_char(s[k]);
  endtask

  function automatic logic [7:0] next_text_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(8'h21, 8'h7E));
    if (r < 55) return lpc_pkg::CH_SP;
    if (r < 62) return lpc_pkg::CH_TAB;
    if (r < 66) return lpc_pkg::CH_CR;
    if (r < 71) return lpc_pkg::CH_BS;
    if (r < 76) return lpc_pkg::CH_LF;
    if (r < 79) return lpc_pkg::CH_FF;
    if (r < 88) begin
      case ($urandom_range(0, 4))
        0: return lpc_pkg::CH_LBRACE;
        1: return lpc_pkg::CH_RBRACE;
        2: return lpc_pkg::CH_GRAVE;
        3: return lpc_pkg::CH_VBAR;
        default: return lpc_pkg::CH_TILDE;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_canon_defaults();
    // reset values: canonical, 132 columns
    send_text("A B");
    send_char(lpc_pkg::CH_TAB);
    send_char("C");
    send_char(lpc_pkg::CH_CR);
    send_char(lpc_pkg::CH_BS);
    send_char("D");
    send_char(lpc_pkg::CH_BS);
    send_char("_");
    send_char(lpc_pkg::CH_LF);
    send_char(lpc_pkg::CH_FF);
    send_char(lpc_pkg::CH_FF);
  endtask

  task automatic test_raw_passthrough();
    set_config(lpc_pkg::MODE_RAW, lpc_pkg::MAX_COL_RST);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(lpc_pkg::CH_LF);
    send_char(lpc_pkg::CH_TAB);
  endtask

  task automatic test_cap_overstrike();
    set_config(lpc_pkg::MODE_CAP, lpc_pkg::MAX_COL_RST);
    send_char(lpc_pkg::CH_LBRACE);
    send_char(lpc_pkg::CH_RBRACE);
    send_char(lpc_pkg::CH_GRAVE);
    send_char(lpc_pkg::CH_VBAR);
    send_char(lpc_pkg::CH_TILDE);
    send_text("az");
    send_char(8'hFF);
  endtask

  task automatic test_narrow_lines();
    // zero width prints nothing; spare mode runs as canonical
    set_config(lpc_pkg::MODE_CANON, '0);
    send_char("A");
    set_config(MODE_SPARE, 10'd1);
    send_text("AB");
    send_char(lpc_pkg::CH_LF);
  endtask

  task automatic test_column_saturation();
    set_config(lpc_pkg::MODE_CANON, 10'd1023);
    send_char("a");
    repeat (130) send_char(lpc_pkg::CH_TAB);
    send_text("bc");
    send_char(lpc_pkg::CH_BS);
    send_char("d");
    set_config(lpc_pkg::MODE_CAP, 10'd1000);
    send_char(lpc_pkg::CH_LBRACE);
    send_char(lpc_pkg::CH_CR);
    send_char(lpc_pkg::CH_TILDE);
    send_char(lpc_pkg::CH_LF);
  endtask

  task automatic test_random_text();
    logic [1:0]                m;
    logic [lpc_pkg::COL_W-1:0] cols;
    int                        r;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      r = $urandom_range(0, 99);
      if (r < 15) m = lpc_pkg::MODE_RAW;
      else if (r < 55) m = lpc_pkg::MODE_CANON;
      else if (r < 90) m = lpc_pkg::MODE_CAP;
      else m = MODE_SPARE;
      r = $urandom_range(0, 99);
      if (r < 5) cols = '0;
      else if (r < 15) cols = 10'd1;
      else if (r < 40) cols = 10'($urandom_range(2, 20));
      else if (r < 85) cols = 10'($urandom_range(21, 132));
      else cols = 10'd1000;
      set_config(m, cols);
      // every fourth phase runs without gaps or stalls
      gaps_on   = (p % 4 != 2);
      stalls_on = (p % 4 != 2);
      for (int i = 0; i < PHASE_CHARS; i++) begin
        if (p == 0 && i == PHASE_CHARS / 2) wait_idle();
        send_char(next_text_char());
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      stall_len = pick_gap(stalls_on);
      if (stall_len > 0) begin
        stall_left <= stall_len - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (printer_beats_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected beat: byte %02h count %0d last %0b",
                   out_byte, out_repeat_count, out_last_of_run);
      end else begin
        due_beat = printer_beats_due.pop_front();
        beats_checked++;
        if (due_beat.data !== out_byte || due_beat.rep !== out_repeat_count ||
            due_beat.last !== out_last_of_run) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: byte %02h/%02h count %0d/%0d last %0b/%0b (exp/got)",
                     due_beat.data, out_byte, due_beat.rep, out_repeat_count,
                     due_beat.last, out_last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int drain_left;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_canon_defaults();
    test_raw_passthrough();
    test_cap_overstrike();
    test_narrow_lines();
    test_column_saturation();
    test_random_text();

    in_valid <= 1'b0;
    drain_left = DRAIN_LIMIT;
    while (printer_beats_due.size() != 0 && drain_left > 0) begin
      @(posedge clk);
      drain_left--;
    end
    repeat (8) @(posedge clk);
    if (printer_beats_due.size() != 0) begin
      $display("%0d predicted beats never arrived", printer_beats_due.size());
      fail_count += printer_beats_due.size();
    end

    $display("%0d characters sent, %0d printer beats checked, %0d register settings",
             chars_sent, beats_checked, cfg_settings);
    $display("modes raw, canonical, cap and spare; widths 0, 1, 132, 1000, 1023");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/lpc_pkg.sv
hdl/lpc_cfg.sv
hdl/lpc_fmt.sv
hdl/lpc_seq.sv
hdl/line_printer_canonicalizer.sv
tb/line_printer_canonicalizer_test.sv
